// File: hdl/ctwl_pkg.sv
// Shared types and constants for the credential table with lockout.
// Used by every module in this folder; depends on nothing else.
`default_nettype none

package ctwl_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0]  ADMIN_ID_RST   = 8'd49;
  localparam logic [31:0] ADMIN_PW_RST   = 32'h3132_3334;
  localparam logic [7:0]  FAIL_LIMIT_RST = 8'd3;
  localparam logic [7:0]  FAIL_MAX       = 8'hFF;

  typedef enum logic [2:0] {
    CMD_AUTH     = 3'd0,
    CMD_REGISTER = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_CHECK    = 3'd3,
    CMD_READ     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ROLE_NONE  = 2'd0,
    ROLE_ADMIN = 2'd1,
    ROLE_USER  = 2'd2
  } role_e;

  typedef enum logic [1:0] {
    CFG_ADMIN_ID   = 2'd0,
    CFG_ADMIN_PW   = 2'd1,
    CFG_FAIL_LIMIT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADMIN,
    S_SCAN,
    S_READ,
    S_READ_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic        from_terminal;
    logic [7:0]  user_id;
    logic [31:0] password;
    logic [7:0]  slot_index;
  } in_t;

  typedef struct packed {
    logic [1:0] role;
    logic       found;
    logic [7:0] slot_id;
    logic [7:0] failed_count;
    logic       alarm;
  } out_t;

  typedef struct packed {
    logic set_active;
    logic clr_active;
  } slot_ctl_t;

  typedef struct packed {
    logic        active;
    logic [7:0]  user_id;
    logic [31:0] password;
  } slot_rd_t;

  typedef struct packed {
    logic id_eq;
    logic pw_eq;
  } match_t;

endpackage

`default_nettype wire

// File: hdl/ctwl_slot_store.sv
// Slot storage: ID and password memories with a registered read port,
// and active marks in flip-flops cleared at reset. Depends on ctwl_pkg.
`default_nettype none

module ctwl_slot_store #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] rd_addr_i,
  input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] wr_addr_i,
  input  ctwl_pkg::slot_ctl_t ctl_i,
  input  logic [7:0]          wr_id_i,
  input  logic [31:0]         wr_pw_i,
  output ctwl_pkg::slot_rd_t  rd_o
);

  logic [7:0]           id_mem [NUM_SLOTS];
  logic [31:0]          pw_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] active_q;
  logic                 rd_act_q;
  logic [7:0]           rd_id_q;
  logic [31:0]          rd_pw_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.set_active) begin
      id_mem[wr_addr_i] <= wr_id_i;
      pw_mem[wr_addr_i] <= wr_pw_i;
    end
    rd_id_q <= id_mem[rd_addr_i];
    rd_pw_q <= pw_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      rd_act_q <= 1'b0;
    end else begin
      if (ctl_i.set_active) begin
        active_q[wr_addr_i] <= 1'b1;
      end else if (ctl_i.clr_active) begin
        active_q[wr_addr_i] <= 1'b0;
      end
      rd_act_q <= active_q[rd_addr_i];
    end
  end

  assign rd_o.active   = rd_act_q;
  assign rd_o.user_id  = rd_id_q;
  assign rd_o.password = rd_pw_q;

endmodule

`default_nettype wire

// File: hdl/ctwl_match_unit.sv
// Shared compare unit: checks an ID and password operand against the request key.
// Serves the admin check and every slot of the scan. Depends on ctwl_pkg.
`default_nettype none

module ctwl_match_unit (
  input  logic [7:0]        key_id_i,
  input  logic [31:0]       key_pw_i,
  input  logic [7:0]        op_id_i,
  input  logic [31:0]       op_pw_i,
  output ctwl_pkg::match_t  match_o
);

  assign match_o.id_eq = (key_id_i == op_id_i);
  assign match_o.pw_eq = (key_pw_i == op_pw_i);

endmodule

`default_nettype wire

// File: hdl/credential_table_with_lockout.sv
// Top level of the credential table: sequencer, configuration and lockout counter.
// Depends on ctwl_pkg, ctwl_slot_store and ctwl_match_unit.
`default_nettype none

// One request is served at a time. Authenticate and check first compare the
// admin account, then walk the slot memory one slot per cycle through the
// single compare unit; register and remove walk the same way. A walk stops at
// the first hit or after the last slot. Reading a slot goes through S_READ, and
// through S_READ_WAIT if the index is in range; unused commands go straight to
// S_DONE. The slot memory's single registered read port sets the
// pace of the walk. The result sits in an output register, so the next item
// can be accepted while it waits to be taken.
module credential_table_with_lockout #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ctwl_pkg::in_t                       in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ctwl_pkg::out_t                      out_o,
  input  logic                                cfg_we_i,
  input  logic [ctwl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ctwl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

  ctwl_pkg::state_e    state_q, state_d;
  ctwl_pkg::in_t       in_q, in_d;
  ctwl_pkg::out_t      out_q, out_d;
  ctwl_pkg::role_e     role_q, role_d;
  logic                found_q, found_d;
  logic [7:0]          sid_q, sid_d;
  logic                out_valid_q, out_valid_d;
  logic [CW-1:0]       iss_q, iss_d;
  logic                rd_vld_q, rd_vld_d;
  logic [AW-1:0]       rd_idx_q, rd_idx_d;
  logic [7:0]          fail_cnt_q, fail_cnt_d;
  logic [7:0]          admin_id_q;
  logic [31:0]         admin_pw_q;
  logic [7:0]          fail_limit_q;

  ctwl_pkg::slot_ctl_t slot_ctl;
  ctwl_pkg::slot_rd_t  slot_rd;
  ctwl_pkg::match_t    match;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          op_id;
  logic [31:0]         op_pw;
  logic                in_acc;
  logic                out_load;
  logic                iss_avail;
  logic                iss_en;
  logic                idx_ok;
  logic                admin_hit;
  logic                scan_hit;
  logic [7:0]          fail_cnt_inc;

  assign in_acc     = in_valid_i && (state_q == ctwl_pkg::S_IDLE);
  assign in_stall_o = (state_q != ctwl_pkg::S_IDLE);
  assign out_load   = (state_q == ctwl_pkg::S_DONE) && (!out_valid_q || !out_stall_i);
  assign iss_avail  = (iss_q < CW'(NUM_SLOTS));
  assign idx_ok     = (in_q.slot_index < 8'(NUM_SLOTS));
  assign fail_cnt_inc = (fail_cnt_q == ctwl_pkg::FAIL_MAX) ? fail_cnt_q : fail_cnt_q + 8'd1;

  assign op_id = (state_q == ctwl_pkg::S_ADMIN) ? admin_id_q : slot_rd.user_id;
  assign op_pw = (state_q == ctwl_pkg::S_ADMIN) ? admin_pw_q : slot_rd.password;

  ctwl_match_unit u_match (
    .key_id_i (in_q.user_id),
    .key_pw_i (in_q.password),
    .op_id_i  (op_id),
    .op_pw_i  (op_pw),
    .match_o  (match)
  );

  ctwl_slot_store #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_addr_i (rd_idx_q),
    .ctl_i     (slot_ctl),
    .wr_id_i   (in_q.user_id),
    .wr_pw_i   (in_q.password),
    .rd_o      (slot_rd)
  );

  assign admin_hit = (in_q.command == ctwl_pkg::CMD_AUTH) ?
                     (in_q.from_terminal && match.id_eq && match.pw_eq) : match.id_eq;

  always_comb begin
    scan_hit = 1'b0;
    if (rd_vld_q) begin
      case (in_q.command) inside
        ctwl_pkg::CMD_AUTH:     scan_hit = slot_rd.active && match.id_eq && match.pw_eq;
        ctwl_pkg::CMD_REGISTER: scan_hit = !slot_rd.active;
        ctwl_pkg::CMD_REMOVE, ctwl_pkg::CMD_CHECK: scan_hit = slot_rd.active && match.id_eq;
        default:                scan_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctwl_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_i.command) inside
            ctwl_pkg::CMD_AUTH, ctwl_pkg::CMD_CHECK:     state_d = ctwl_pkg::S_ADMIN;
            ctwl_pkg::CMD_REGISTER, ctwl_pkg::CMD_REMOVE: state_d = ctwl_pkg::S_SCAN;
            ctwl_pkg::CMD_READ:                          state_d = ctwl_pkg::S_READ;
            default:                                     state_d = ctwl_pkg::S_DONE;
          endcase
        end
      end
      ctwl_pkg::S_ADMIN:     state_d = admin_hit ? ctwl_pkg::S_DONE : ctwl_pkg::S_SCAN;
      ctwl_pkg::S_SCAN: begin
        if (scan_hit || !iss_avail) begin
          state_d = ctwl_pkg::S_DONE;
        end
      end
      ctwl_pkg::S_READ:      state_d = idx_ok ? ctwl_pkg::S_READ_WAIT : ctwl_pkg::S_DONE;
      ctwl_pkg::S_READ_WAIT: state_d = ctwl_pkg::S_DONE;
      ctwl_pkg::S_DONE: begin
        if (out_load) begin
          state_d = ctwl_pkg::S_IDLE;
        end
      end
      default:               state_d = ctwl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_d       = in_q;
    role_d     = role_q;
    found_d    = found_q;
    sid_d      = sid_q;
    iss_en     = 1'b0;
    slot_ctl   = '0;
    rd_addr    = iss_q[AW-1:0];
    out_d      = out_q;
    fail_cnt_d = fail_cnt_q;
    unique case (state_q)
      ctwl_pkg::S_IDLE: begin
        if (in_acc) begin
          in_d    = in_i;
          role_d  = ctwl_pkg::ROLE_NONE;
          found_d = 1'b0;
          sid_d   = 8'd0;
        end
      end
      ctwl_pkg::S_ADMIN: begin
        iss_en = iss_avail;
        if (admin_hit) begin
          if (in_q.command == ctwl_pkg::CMD_AUTH) begin
            role_d = ctwl_pkg::ROLE_ADMIN;
          end else begin
            found_d = 1'b1;
          end
        end
      end
      ctwl_pkg::S_SCAN: begin
        iss_en = iss_avail && !scan_hit;
        if (scan_hit) begin
          case (in_q.command) inside
            ctwl_pkg::CMD_AUTH: role_d = ctwl_pkg::ROLE_USER;
            ctwl_pkg::CMD_REGISTER: begin
              found_d             = 1'b1;
              slot_ctl.set_active = 1'b1;
            end
            ctwl_pkg::CMD_REMOVE: begin
              found_d             = 1'b1;
              slot_ctl.clr_active = 1'b1;
            end
            default: found_d = 1'b1;
          endcase
        end
      end
      ctwl_pkg::S_READ: begin
        rd_addr = in_q.slot_index[AW-1:0];
      end
      ctwl_pkg::S_READ_WAIT: begin
        found_d = slot_rd.active;
        sid_d   = slot_rd.active ? slot_rd.user_id : 8'd0;
      end
      ctwl_pkg::S_DONE: begin
        if (out_load) begin
          out_d.role    = role_q;
          out_d.found   = found_q;
          out_d.slot_id = sid_q;
          out_d.alarm   = 1'b0;
          if (in_q.command == ctwl_pkg::CMD_AUTH) begin
            if (role_q != ctwl_pkg::ROLE_NONE) begin
              fail_cnt_d = 8'd0;
            end else begin
              fail_cnt_d  = fail_cnt_inc;
              out_d.alarm = (fail_cnt_inc >= fail_limit_q);
            end
          end
          out_d.failed_count = fail_cnt_d;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    iss_d    = (state_q == ctwl_pkg::S_IDLE) ? '0 : iss_q;
    if (iss_en) begin
      iss_d = iss_q + CW'(1);
    end
    rd_vld_d = iss_en && (state_d == ctwl_pkg::S_SCAN);
    rd_idx_d = iss_q[AW-1:0];
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctwl_pkg::S_IDLE;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      fail_cnt_q  <= 8'd0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      fail_cnt_q  <= fail_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    role_q   <= role_d;
    found_q  <= found_d;
    sid_q    <= sid_d;
    rd_idx_q <= rd_idx_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      admin_id_q   <= ctwl_pkg::ADMIN_ID_RST;
      admin_pw_q   <= ctwl_pkg::ADMIN_PW_RST;
      fail_limit_q <= ctwl_pkg::FAIL_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ctwl_pkg::CFG_ADMIN_ID:   admin_id_q   <= cfg_wdata_i[7:0];
        ctwl_pkg::CFG_ADMIN_PW:   admin_pw_q   <= cfg_wdata_i[31:0];
        ctwl_pkg::CFG_FAIL_LIMIT: fail_limit_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a second item while busy");

  a_alarm_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.alarm |-> out_o.role == ctwl_pkg::ROLE_NONE)
    else $error("alarm raised on a successful login");

  a_success_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.role != ctwl_pkg::ROLE_NONE |-> out_o.failed_count == 8'd0)
    else $error("failure count not cleared by a successful login");

  a_slot_ctl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({slot_ctl.set_active, slot_ctl.clr_active}))
    else $error("slot set and clear in the same cycle");

endmodule

`default_nettype wire
